/* hw/rtl/diameter_avp_stream_parser_assert.svh */
// Assertion macros used by the RTL of the AVP stream parser.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DIAMETER_AVP_STREAM_PARSER_ASSERT_SVH
`define DIAMETER_AVP_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DAVP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DAVP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/davp_pkg.sv */
package davp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Final status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
    localparam logic [1:0] STATUS_OVERRUN   = 2'd3;

    // Header lengths and padding alignment.
    localparam logic [23:0] HDR_LEN_PLAIN  = 24'd8;
    localparam logic [23:0] HDR_LEN_VENDOR = 24'd12;
    localparam logic [1:0]  PAD_MASK       = 2'd3;

    localparam logic [7:0] VENDOR_MASK_RESET = 8'd128;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] avp_code;
        logic [7:0]  avp_flags;
        logic [31:0] avp_vendor;
        logic [23:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic        buffer_end;
        logic [1:0]  status;
    } out_beat_t;

endpackage

/* hw/rtl/davp_if.sv */
// Byte channel into the parser.
interface davp_in_if;
    import davp_pkg::*;

    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel out of the parser.
interface davp_out_if;
    import davp_pkg::*;

    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/diameter_avp_stream_parser.sv */
// Diameter AVP stream parser. Takes one buffer byte per beat and produces at most one result
// beat per byte: a header beat when a pair's header is complete, one beat per payload byte,
// and always one beat for the buffer's last byte carrying the final status. The block
// accepts a byte every cycle and the result is registered in the output register; the
// byte input stalls only while that register holds a beat the sink has not taken. Bytes
// that yield no result (padding, header bytes before completion, bytes after an error) are
// still consumed from the input. The user must write the vendor flag mask through the
// configuration port only while the block is idle; the block itself does not enforce this.
`include "diameter_avp_stream_parser_assert.svh"

module diameter_avp_stream_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data,
    davp_in_if.sink        avp_bytes,
    davp_out_if.source     avp_results
);
    import davp_pkg::*;

    // Parse phases.
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_PAD     = 2'd2;
    localparam logic [1:0] PH_ERROR   = 2'd3;

    logic [7:0]  mask_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [23:0] byte_count_reg, byte_count_next;
    logic [31:0] code_reg, code_next;
    logic [7:0]  flags_reg, flags_next;
    logic [23:0] length_reg, length_next;
    logic [31:0] vendor_reg, vendor_next;
    logic [1:0]  error_code_reg, error_code_next;

    logic        out_valid_reg;
    out_beat_t   out_data_reg, out_data_next;
    logic        emit;

    logic        accept;
    logic [7:0]  b;
    logic        eob;
    logic        vendor_present;
    logic [23:0] hdr_len;
    logic [23:0] plen;
    logic [23:0] left;
    logic [1:0]  pad_cur;
    logic [1:0]  pad_new;
    logic        complete;
    logic        pending;
    logic [1:0]  trunc_st;

    assign accept = avp_bytes.valid && avp_bytes.ready;
    assign b      = avp_bytes.data.in_byte;
    assign eob    = avp_bytes.data.end_of_buffer;

    // Header view built from the values after this byte is folded in.
    assign vendor_present = |(flags_next & mask_reg);
    assign hdr_len    = vendor_present ? HDR_LEN_VENDOR : HDR_LEN_PLAIN;
    assign plen       = length_next - hdr_len;
    assign left       = byte_count_reg - 24'd1;
    assign pad_cur    = (2'd0 - length_reg[1:0]) & PAD_MASK;
    assign pad_new    = (2'd0 - length_next[1:0]) & PAD_MASK;

    // Next-state and result logic for one byte.
    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        code_next       = code_reg;
        flags_next      = flags_reg;
        length_next     = length_reg;
        vendor_next     = vendor_reg;
        error_code_next = error_code_reg;
        complete        = 1'b0;
        pending         = 1'b0;
        trunc_st        = STATUS_OK;
        emit            = 1'b0;
        out_data_next   = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                // Shift the byte into the header field it belongs to.
                if (byte_count_reg == 24'd0)
                begin
                    code_next   = {24'd0, b};
                    flags_next  = 8'd0;
                    length_next = 24'd0;
                    vendor_next = 32'd0;
                end
                else if (byte_count_reg < 24'd4)
                begin
                    code_next = {code_reg[23:0], b};
                end
                else if (byte_count_reg == 24'd4)
                begin
                    flags_next = b;
                end
                else if (byte_count_reg < 24'd8)
                begin
                    length_next = {length_reg[15:0], b};
                end
                else
                begin
                    vendor_next = {vendor_reg[23:0], b};
                end
                byte_count_next = byte_count_reg + 24'd1;

                // Length check on the last fixed header byte.
                if (byte_count_reg == 24'd7)
                begin
                    if (length_next < hdr_len)
                    begin
                        phase_next      = PH_ERROR;
                        error_code_next = STATUS_TOO_SHORT;
                    end
                    else if (!vendor_present)
                    begin
                        complete = 1'b1;
                    end
                end
                else if (byte_count_reg >= 24'd11)
                begin
                    complete = 1'b1;
                end

                if (phase_next == PH_ERROR)
                begin
                    pending = 1'b0;
                end
                else if (complete)
                begin
                    emit = 1'b1;
                    out_data_next.kind           = KIND_HEADER;
                    out_data_next.avp_code       = code_next;
                    out_data_next.avp_flags      = flags_next;
                    out_data_next.avp_vendor     = vendor_present ? vendor_next : 32'd0;
                    out_data_next.payload_length = plen;
                    if (plen != 24'd0)
                    begin
                        phase_next      = PH_PAYLOAD;
                        byte_count_next = plen;
                        pending         = 1'b1;
                    end
                    else
                    begin
                        phase_next      = (pad_new != 2'd0) ? PH_PAD : PH_HEADER;
                        byte_count_next = {22'd0, pad_new};
                    end
                end
                else
                begin
                    pending  = 1'b1;
                    trunc_st = (byte_count_reg < 24'd7) ? STATUS_TRUNCATED : STATUS_OVERRUN;
                end

                // Buffer ending with the pair still open.
                if (eob && pending && !complete)
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = trunc_st;
                end
                else if (eob && pending && complete)
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = STATUS_OVERRUN;
                end
            end

            PH_PAYLOAD:
            begin
                byte_count_next = left;
                emit = 1'b1;
                out_data_next.kind           = KIND_PAYLOAD;
                out_data_next.avp_code       = code_reg;
                out_data_next.avp_flags      = flags_reg;
                out_data_next.avp_vendor     = vendor_present ? vendor_reg : 32'd0;
                out_data_next.payload_length = plen;
                out_data_next.payload_byte   = b;
                out_data_next.last_payload   = (left == 24'd0);
                if (left == 24'd0)
                begin
                    phase_next      = (pad_cur != 2'd0) ? PH_PAD : PH_HEADER;
                    byte_count_next = {22'd0, pad_cur};
                end
                else if (eob)
                begin
                    phase_next      = PH_ERROR;
                    error_code_next = STATUS_OVERRUN;
                end
            end

            PH_PAD:
            begin
                byte_count_next = left;
                if (left == 24'd0)
                begin
                    phase_next = PH_HEADER;
                end
            end

            default:
            begin
                // Error phase: bytes are dropped until the buffer ends.
                phase_next = phase_reg;
            end
        endcase

        // The buffer's last byte always yields a beat with the final status.
        if (eob)
        begin
            if (!emit)
            begin
                out_data_next      = '0;
                out_data_next.kind = KIND_STATUS;
            end
            emit = 1'b1;
            out_data_next.buffer_end = 1'b1;
            out_data_next.status     = (phase_next == PH_ERROR) ? error_code_next : STATUS_OK;
            phase_next      = PH_HEADER;
            byte_count_next = 24'd0;
            error_code_next = STATUS_OK;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= VENDOR_MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            mask_reg <= cfg_wr_data;
        end
    end

    // Parse state, updated on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= 24'd0;
            code_reg       <= 32'd0;
            flags_reg      <= 8'd0;
            length_reg     <= 24'd0;
            vendor_reg     <= 32'd0;
            error_code_reg <= STATUS_OK;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            code_reg       <= code_next;
            flags_reg      <= flags_next;
            length_reg     <= length_next;
            vendor_reg     <= vendor_next;
            error_code_reg <= error_code_next;
        end
    end

    // Result register: a new beat loads whenever the old one is gone or taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (avp_bytes.ready)
        begin
            out_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign avp_bytes.ready   = !out_valid_reg || avp_results.ready;
    assign avp_results.valid = out_valid_reg;
    assign avp_results.data  = out_data_reg;

    // Checks on the parser's own logic.
    `DAVP_ASSERT_NOW(a_stall_blocks_input,
        out_valid_reg && !avp_results.ready, !avp_bytes.ready,
        "byte input open while a result beat is stalled")
    `DAVP_ASSERT_NOW(a_status_only_at_end,
        out_valid_reg && (out_data_reg.kind == KIND_STATUS), out_data_reg.buffer_end,
        "status-only beat without buffer end")
    `DAVP_ASSERT_NOW(a_last_only_on_payload,
        out_valid_reg && out_data_reg.last_payload, out_data_reg.kind == KIND_PAYLOAD,
        "last payload mark on a non-payload beat")
    `DAVP_ASSERT_NEXT(a_end_restarts_parse,
        accept && eob,
        (phase_reg == PH_HEADER) && (byte_count_reg == 24'd0) && out_valid_reg,
        "buffer end did not restart the parse with a result")
    `DAVP_ASSERT_NOW(a_payload_count_nonzero,
        phase_reg == PH_PAYLOAD, byte_count_reg != 24'd0,
        "payload phase with no bytes left")

endmodule
